@@ design/salc_pkg.sv @@
// ----------------------------------------------------------------------------
// salc_pkg: shared types and constants of the LRU cache tag simulator
// Command and register codes, sequencer states, field widths and the
// saturating counter update.
// ----------------------------------------------------------------------------
package salc_pkg;

  // Default sizing of the tag store
  localparam int DEF_MAX_SET_BITS = 6;
  localparam int DEF_MAX_WAYS     = 8;
  localparam int DEF_ADDR_WIDTH   = 64;

  // Fixed field widths
  localparam int ADDR_PORT_W  = 64;
  localparam int CMD_W        = 2;
  localparam int CNT_W        = 32;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 6;
  localparam int SET_BITS_W   = 3;
  localparam int WAYS_REG_W   = 4;
  localparam int BLOCK_BITS_W = 6;

  localparam logic [WAYS_REG_W-1:0] WAYS_RESET = WAYS_REG_W'(1);

  typedef enum logic [CMD_W-1:0] {
    CMD_IFETCH = 2'd0,
    CMD_LOAD   = 2'd1,
    CMD_STORE  = 2'd2,
    CMD_MODIFY = 2'd3
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SET_BITS   = 2'd0,
    CFG_WAYS       = 2'd1,
    CFG_BLOCK_BITS = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SPLIT,
    ST_CMP,
    ST_UPD
  } state_e;

  // Add 0, 1 or 2 and clamp at all ones
  function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] cnt,
                                               input logic [1:0]       inc);
    logic [CNT_W:0] sum;
    sum = {1'b0, cnt} + (CNT_W + 1)'(inc);
    return sum[CNT_W] ? {CNT_W{1'b1}} : sum[CNT_W-1:0];
  endfunction

endpackage

@@ design/salc_access_if.sv @@
// ----------------------------------------------------------------------------
// salc_access_if: access channel
// One word carries an access kind and a byte address.
// ----------------------------------------------------------------------------
interface salc_access_if import salc_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [CMD_W-1:0]       command;
  logic [ADDR_PORT_W-1:0] address;

  modport source (output valid, output command, output address, input ready);
  modport sink   (input valid, input command, input address, output ready);
endinterface

@@ design/salc_result_if.sv @@
// ----------------------------------------------------------------------------
// salc_result_if: result channel
// One word carries the outcome of a data access and the running totals.
// ----------------------------------------------------------------------------
interface salc_result_if import salc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             hit;
  logic             eviction;
  logic             modify_hit;
  logic [CNT_W-1:0] hit_count;
  logic [CNT_W-1:0] miss_count;
  logic [CNT_W-1:0] eviction_count;

  modport source (output valid, output hit, output eviction, output modify_hit,
                  output hit_count, output miss_count, output eviction_count,
                  input ready);
  modport sink   (input valid, input hit, input eviction, input modify_hit,
                  input hit_count, input miss_count, input eviction_count,
                  output ready);
endinterface

@@ design/set_associative_lru_cache_sim_top.sv @@
// ----------------------------------------------------------------------------
// set_associative_lru_cache_sim_top: LRU set-associative cache tag simulator
//
//   channel    dir   handshake          word
//   access_i   in    valid / ready      command, address
//   result_o   out   valid / ready      hit, eviction, modify_hit, 3 counters
//   cfg        in    cfg_we_i           cfg_index_i, cfg_wdata_i
//
// A data access goes through accept, split and set read, one tag compare
// per way on the shared comparator, then row write-back.
// An instruction fetch is accepted and dropped in the idle state and gives no word.
// Reset empties every set at once through one init flag per set; so does
// a write of the ways register. No clearing pass follows.
// The result register holds a word until taken; the next access is accepted
// meanwhile, and its write-back waits while that word is still pending.
// ----------------------------------------------------------------------------
module set_associative_lru_cache_sim_top import salc_pkg::*; #(
  parameter int MAX_SET_BITS = DEF_MAX_SET_BITS,
  parameter int MAX_WAYS     = DEF_MAX_WAYS,
  parameter int ADDR_WIDTH   = DEF_ADDR_WIDTH
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  salc_access_if.sink           access_i,
  salc_result_if.source         result_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  localparam int NUM_SETS = 1 << MAX_SET_BITS;
  localparam int SET_W    = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
  localparam int WAY_W    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int RANK_W   = WAY_W;
  localparam int WAYS_W   = $clog2(MAX_WAYS + 1);
  localparam int SHAMT_W  = 7;
  localparam int SB_W     = 4;

  typedef struct packed {
    logic [MAX_WAYS-1:0]                 valid;
    logic [MAX_WAYS-1:0][RANK_W-1:0]     rank;
    logic [MAX_WAYS-1:0][ADDR_WIDTH-1:0] tag;
  } row_t;

  // Configuration
  logic [SET_BITS_W-1:0]   set_bits_q;
  logic [WAYS_REG_W-1:0]   ways_q;
  logic [BLOCK_BITS_W-1:0] block_bits_q;
  logic                    flush;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      set_bits_q   <= '0;
      ways_q       <= WAYS_RESET;
      block_bits_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_SET_BITS:   set_bits_q   <= cfg_wdata_i[SET_BITS_W-1:0];
        CFG_WAYS:       ways_q       <= cfg_wdata_i[WAYS_REG_W-1:0];
        CFG_BLOCK_BITS: block_bits_q <= cfg_wdata_i[BLOCK_BITS_W-1:0];
        default:        ;
      endcase
    end
  end

  assign flush = cfg_we_i && (cfg_idx_e'(cfg_index_i) == CFG_WAYS);

  // Effective set bits and associativity
  logic [SB_W-1:0]   sb_eff;
  logic [WAYS_W-1:0] ways_eff;

  always_comb begin
    sb_eff = ({1'b0, set_bits_q} > SB_W'(MAX_SET_BITS)) ? SB_W'(MAX_SET_BITS)
                                                        : {1'b0, set_bits_q};
    if (ways_q == '0) begin
      ways_eff = WAYS_W'(1);
    end else if (32'(ways_q) > 32'(MAX_WAYS)) begin
      ways_eff = WAYS_W'(MAX_WAYS);
    end else begin
      ways_eff = WAYS_W'(ways_q);
    end
  end

  // Sequencer registers
  state_e                state_q, state_d;
  cmd_e                  cmd_q, cmd_d;
  logic [ADDR_WIDTH-1:0] addr_q, addr_d;
  logic [SET_W-1:0]      set_q, set_d;
  logic [ADDR_WIDTH-1:0] tag_q, tag_d;
  logic [WAY_W-1:0]      way_q, way_d;
  logic                  hit_q, hit_d;
  logic [WAY_W-1:0]      hit_way_q, hit_way_d;
  logic                  vic_found_q, vic_found_d;
  logic [WAY_W-1:0]      vic_q, vic_d;
  logic                  rd_en, wr_en, load;

  // Set and tag split
  logic [SHAMT_W-1:0]    tag_shamt;
  logic [ADDR_WIDTH-1:0] blk_shifted;
  logic [SET_W-1:0]      set_mask;
  logic [SET_W-1:0]      set_calc;
  logic [ADDR_WIDTH-1:0] tag_calc;

  always_comb begin
    tag_shamt   = SHAMT_W'(block_bits_q) + SHAMT_W'(sb_eff);
    blk_shifted = (32'(block_bits_q) >= ADDR_WIDTH) ? '0 : (addr_q >> block_bits_q);
    for (int j = 0; j < SET_W; j++) begin
      set_mask[j] = (j < 32'(sb_eff));
    end
    set_calc = blk_shifted[SET_W-1:0] & set_mask;
    tag_calc = (32'(tag_shamt) >= ADDR_WIDTH) ? '0 : (addr_q >> tag_shamt);
  end

  // Tag store: one row per set
  row_t mem_q [NUM_SETS];
  row_t rd_q;
  row_t row_new;
  logic [NUM_SETS-1:0] init_q;
  logic                init_rd_q;

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_q <= mem_q[set_d];
    end
    if (wr_en) begin
      mem_q[set_q] <= row_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_q    <= '0;
      init_rd_q <= 1'b0;
    end else begin
      if (rd_en) begin
        init_rd_q <= init_q[set_d];
      end
      if (flush) begin
        init_q <= '0;
      end else if (wr_en) begin
        init_q[set_q] <= 1'b1;
      end
    end
  end

  // A set never written since reset or the last flush reads as empty with reset ranks
  logic [MAX_WAYS-1:0]             valid_eff;
  logic [MAX_WAYS-1:0][RANK_W-1:0] rank_eff;

  always_comb begin
    for (int i = 0; i < MAX_WAYS; i++) begin
      valid_eff[i] = init_rd_q && rd_q.valid[i];
      rank_eff[i]  = init_rd_q ? rd_q.rank[i] : RANK_W'(i);
    end
  end

  // Shared comparator: one way per cycle
  logic tag_match;
  logic rank_zero;
  logic last_way;

  assign tag_match = valid_eff[way_q] && (rd_q.tag[way_q] == tag_q);
  assign rank_zero = (rank_eff[way_q] == '0);
  assign last_way  = ((32'(way_q) + 32'd1) == 32'(ways_eff));

  // Row write-back with LRU rank update
  logic [WAY_W-1:0]  use_way;
  logic [RANK_W-1:0] use_pos;
  logic              evict;

  always_comb begin
    use_way = hit_q ? hit_way_q : vic_q;
    use_pos = rank_eff[use_way];
    evict   = !hit_q && valid_eff[vic_q];
    row_new = rd_q;
    for (int i = 0; i < MAX_WAYS; i++) begin
      row_new.valid[i] = valid_eff[i];
      row_new.rank[i]  = rank_eff[i];
      if ((i < 32'(ways_eff)) && (rank_eff[i] > use_pos)) begin
        row_new.rank[i] = rank_eff[i] - RANK_W'(1);
      end
    end
    row_new.rank[use_way] = RANK_W'(ways_eff - WAYS_W'(1));
    if (!hit_q) begin
      row_new.valid[use_way] = 1'b1;
      row_new.tag[use_way]   = tag_q;
    end
  end

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q       <= cmd_d;
    addr_q      <= addr_d;
    set_q       <= set_d;
    tag_q       <= tag_d;
    way_q       <= way_d;
    hit_q       <= hit_d;
    hit_way_q   <= hit_way_d;
    vic_found_q <= vic_found_d;
    vic_q       <= vic_d;
  end

  logic out_valid_q;

  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    addr_d      = addr_q;
    set_d       = set_q;
    tag_d       = tag_q;
    way_d       = way_q;
    hit_d       = hit_q;
    hit_way_d   = hit_way_q;
    vic_found_d = vic_found_q;
    vic_d       = vic_q;
    rd_en       = 1'b0;
    wr_en       = 1'b0;
    load        = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (access_i.valid) begin
          cmd_d  = cmd_e'(access_i.command);
          addr_d = access_i.address[ADDR_WIDTH-1:0];
          // drop instruction fetches right here
          if (cmd_e'(access_i.command) != CMD_IFETCH) begin
            state_d = ST_SPLIT;
          end
        end
      end
      ST_SPLIT: begin
        set_d       = set_calc;
        tag_d       = tag_calc;
        rd_en       = 1'b1;
        way_d       = '0;
        hit_d       = 1'b0;
        hit_way_d   = '0;
        vic_found_d = 1'b0;
        vic_d       = '0;
        state_d     = ST_CMP;
      end
      ST_CMP: begin
        if (!hit_q && tag_match) begin
          hit_d     = 1'b1;
          hit_way_d = way_q;
        end
        if (!vic_found_q && rank_zero) begin
          vic_found_d = 1'b1;
          vic_d       = way_q;
        end
        if (last_way) begin
          state_d = ST_UPD;
        end else begin
          way_d = way_q + WAY_W'(1);
        end
      end
      ST_UPD: begin
        // hold until the result register is free
        if (!out_valid_q || result_o.ready) begin
          load    = 1'b1;
          wr_en   = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign access_i.ready = (state_q == ST_IDLE);

  // Counters and result register
  logic [CNT_W-1:0] hits_q, misses_q, evicts_q;
  logic             res_hit_q, res_evict_q, res_modify_q;
  logic [1:0]       hit_inc;

  assign hit_inc = {1'b0, hit_q} + {1'b0, (cmd_q == CMD_MODIFY)};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      hits_q      <= '0;
      misses_q    <= '0;
      evicts_q    <= '0;
    end else begin
      if (load) begin
        out_valid_q <= 1'b1;
        hits_q      <= sat_add(hits_q, hit_inc);
        misses_q    <= sat_add(misses_q, {1'b0, !hit_q});
        evicts_q    <= sat_add(evicts_q, {1'b0, evict});
      end else if (result_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      res_hit_q    <= hit_q;
      res_evict_q  <= evict;
      res_modify_q <= (cmd_q == CMD_MODIFY);
    end
  end

  assign result_o.valid          = out_valid_q;
  assign result_o.hit            = res_hit_q;
  assign result_o.eviction       = res_evict_q;
  assign result_o.modify_hit     = res_modify_q;
  assign result_o.hit_count      = hits_q;
  assign result_o.miss_count     = misses_q;
  assign result_o.eviction_count = evicts_q;

  // Assertions
  a_hit_no_evict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(res_hit_q && res_evict_q))
    else $error("eviction flagged on a hit");

  a_way_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CMP) |-> (32'(way_q) < 32'(ways_eff)))
    else $error("way counter beyond associativity");

  a_miss_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> ((misses_q == $past(misses_q)) ||
              (misses_q == $past(misses_q) + CNT_W'(1))))
    else $error("miss count moved by more than one");

  a_count_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !load |=> ($stable(hits_q) && $stable(misses_q) && $stable(evicts_q)))
    else $error("counters changed without a result");

  a_victim_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && !hit_q) |-> vic_found_q)
    else $error("miss without a least recent way");

endmodule

@@ verif/tb_set_associative_lru_cache_sim_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_set_associative_lru_cache_sim_top: testbench of the LRU cache tag simulator
// A directed table checks the first accesses against typed outcomes and
// covers the register corner values. Random phases follow, each with its own
// geometry. They draw addresses from small pools of sets and tags so that
// hits, refills and evictions all occur. Every result word is checked
// against a local LRU tag model, and both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_set_associative_lru_cache_sim_top;
  import salc_pkg::*;

  localparam int NSETS           = 1 << DEF_MAX_SET_BITS;
  localparam int NWAYS           = DEF_MAX_WAYS;
  localparam int SETTLE_CYCLES   = 24;
  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int N_PHASES        = 10;
  localparam int ITEMS_PER_PHASE = 125;

  typedef struct packed {
    logic             hit;
    logic             eviction;
    logic             modify_hit;
    logic [CNT_W-1:0] hit_count;
    logic [CNT_W-1:0] miss_count;
    logic [CNT_W-1:0] eviction_count;
  } outcome_t;

  typedef struct packed {
    logic     known;
    outcome_t exp;
  } typed_check_t;

  typedef enum logic {ROW_ACCESS, ROW_WRITE} row_kind_e;

  typedef struct packed {
    row_kind_e             kind;
    cfg_idx_e              reg_idx;
    logic [CFG_DATA_W-1:0] reg_val;
    cmd_e                  cmd;
    logic [63:0]           addr;
    logic                  known;
    outcome_t              exp;
  } row_t;

  localparam int N_DIRECTED = 21;
  localparam logic [63:0] ONES = {64{1'b1}};

  // Reset geometry is one set of one way, so the first rows read off directly
  localparam row_t DIRECTED [N_DIRECTED] = '{
    '{ROW_ACCESS, CFG_SET_BITS, 6'd0, CMD_LOAD, 64'h0, 1'b1, '{0, 0, 0, 0, 1, 0}},
    '{ROW_ACCESS, CFG_SET_BITS, 6'd0, CMD_LOAD, 64'h0, 1'b1, '{1, 0, 0, 1, 1, 0}},
    '{ROW_ACCESS, CFG_SET_BITS, 6'd0, CMD_IFETCH, ONES, 1'b0, '0},
    '{ROW_ACCESS, CFG_SET_BITS, 6'd0, CMD_STORE, ONES, 1'b1, '{0, 1, 0, 1, 2, 1}},
    '{ROW_ACCESS, CFG_SET_BITS, 6'd0, CMD_MODIFY, ONES, 1'b1, '{1, 0, 1, 3, 2, 1}},
    '{ROW_ACCESS, CFG_SET_BITS, 6'd0, CMD_MODIFY, 64'h0, 1'b1, '{0, 1, 1, 4, 3, 2}},
    // shift past the top of the address: tag becomes zero
    '{ROW_WRITE, CFG_BLOCK_BITS, 6'd63, CMD_IFETCH, 64'h0, 1'b0, '0},
    '{ROW_WRITE, CFG_SET_BITS, 6'd7, CMD_IFETCH, 64'h0, 1'b0, '0},
    '{ROW_WRITE, CFG_WAYS, 6'd0, CMD_IFETCH, 64'h0, 1'b0, '0},
    '{ROW_ACCESS, CFG_SET_BITS, 6'd0, CMD_LOAD, 64'h8000_0000_0000_0000, 1'b1,
      '{0, 0, 0, 4, 4, 2}},
    '{ROW_ACCESS, CFG_SET_BITS, 6'd0, CMD_LOAD, 64'h7fff_ffff_ffff_ffff, 1'b1,
      '{0, 0, 0, 4, 5, 2}},
    '{ROW_ACCESS, CFG_SET_BITS, 6'd0, CMD_STORE, ONES, 1'b1, '{1, 0, 0, 5, 5, 2}},
    '{ROW_WRITE, CFG_WAYS, 6'd15, CMD_IFETCH, 64'h0, 1'b0, '0},
    '{ROW_WRITE, CFG_BLOCK_BITS, 6'd0, CMD_IFETCH, 64'h0, 1'b0, '0},
    '{ROW_WRITE, CFG_SET_BITS, 6'd0, CMD_IFETCH, 64'h0, 1'b0, '0},
    '{ROW_ACCESS, CFG_SET_BITS, 6'd0, CMD_LOAD, 64'ha, 1'b0, '0},
    '{ROW_ACCESS, CFG_SET_BITS, 6'd0, CMD_LOAD, 64'hb, 1'b0, '0},
    '{ROW_ACCESS, CFG_SET_BITS, 6'd0, CMD_LOAD, 64'ha, 1'b0, '0},
    '{ROW_ACCESS, CFG_SET_BITS, 6'd0, CMD_MODIFY, 64'hc, 1'b0, '0},
    '{ROW_ACCESS, CFG_SET_BITS, 6'd0, CMD_IFETCH, 64'h0, 1'b0, '0},
    '{ROW_ACCESS, CFG_SET_BITS, 6'd0, CMD_STORE, 64'h5555_5555_5555_5555, 1'b0, '0}
  };

  // First random phases pin the register extremes
  localparam int PHASE_SB   [6] = '{6, 7, 0, 3, 2, 6};
  localparam int PHASE_WAYS [6] = '{8, 15, 1, 0, 4, 8};
  localparam int PHASE_BB   [6] = '{32, 0, 63, 60, 5, 6};

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;

  salc_access_if acc_if ();
  salc_result_if res_if ();

  set_associative_lru_cache_sim_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .access_i   (acc_if),
    .result_o   (res_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  always #6 clk_i = ~clk_i;

  // Tag model state
  logic [SET_BITS_W-1:0]   set_bits_q   = '0;
  logic [WAYS_REG_W-1:0]   ways_q       = WAYS_RESET;
  logic [BLOCK_BITS_W-1:0] block_bits_q = '0;
  logic                    way_valid [NSETS][NWAYS];
  logic [63:0]             way_tag   [NSETS][NWAYS];
  logic [2:0]              way_rank  [NSETS][NWAYS];
  logic [CNT_W-1:0]        hits_seen      = '0;
  logic [CNT_W-1:0]        misses_seen    = '0;
  logic [CNT_W-1:0]        evictions_seen = '0;

  outcome_t     pending_outcomes [$];
  typed_check_t typed_checks [$];
  int           failures     = 0;
  int           quiet_cycles = 0;
  int           burst_left   = 1;

  function automatic int eff_set_bits();
    return (set_bits_q > DEF_MAX_SET_BITS) ? DEF_MAX_SET_BITS : int'(set_bits_q);
  endfunction

  function automatic int eff_ways();
    if (ways_q == 0) return 1;
    return (ways_q > NWAYS) ? NWAYS : int'(ways_q);
  endfunction

  function automatic logic [63:0] shr64(input logic [63:0] v, input int n);
    return (n >= 64) ? 64'd0 : (v >> n);
  endfunction

  function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] c);
    return (c == {CNT_W{1'b1}}) ? c : c + 1'b1;
  endfunction

  function automatic void flush_model();
    for (int s = 0; s < NSETS; s++) begin
      for (int w = 0; w < NWAYS; w++) begin
        way_valid[s][w] = 1'b0;
        way_tag[s][w]   = '0;
        way_rank[s][w]  = 3'(w);
      end
    end
  endfunction

  // Look the access up, update LRU order and totals; 0 if no word is due
  function automatic bit cache_lookup(input cmd_e c, input logic [63:0] a,
                                      output outcome_t o);
    int          sb;
    int          nw;
    int          s;
    int          victim;
    logic [63:0] tg;
    logic [2:0]  pos;
    bit          hit;
    bit          ev;
    o = '0;
    if (c == CMD_IFETCH) return 0;
    sb     = eff_set_bits();
    nw     = eff_ways();
    s      = int'(shr64(a, int'(block_bits_q)) & ((64'd1 << sb) - 1));
    tg     = shr64(a, int'(block_bits_q) + sb);
    hit    = 0;
    ev     = 0;
    victim = 0;
    for (int w = 0; w < nw; w++) begin
      if (way_valid[s][w] && way_tag[s][w] == tg) begin
        hit    = 1;
        victim = w;
        break;
      end
    end
    if (hit) begin
      hits_seen = bump(hits_seen);
    end else begin
      for (int w = 0; w < nw; w++) begin
        if (way_rank[s][w] == 0) begin
          victim = w;
          break;
        end
      end
      ev                   = way_valid[s][victim];
      way_valid[s][victim] = 1'b1;
      way_tag[s][victim]   = tg;
      misses_seen          = bump(misses_seen);
      if (ev) evictions_seen = bump(evictions_seen);
    end
    // promote the touched way to most recent
    pos = way_rank[s][victim];
    for (int w = 0; w < nw; w++) begin
      if (way_rank[s][w] > pos) way_rank[s][w] = way_rank[s][w] - 1'b1;
    end
    way_rank[s][victim] = 3'(nw - 1);
    if (c == CMD_MODIFY) hits_seen = bump(hits_seen);
    o.hit            = hit;
    o.eviction       = ev;
    o.modify_hit     = (c == CMD_MODIFY);
    o.hit_count      = hits_seen;
    o.miss_count     = misses_seen;
    o.eviction_count = evictions_seen;
    return 1;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      failures++;
    end
  endfunction

  // Write one register; the caller drops the enable after the last write
  task automatic write_reg(input cfg_idx_e idx, input int val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= CFG_DATA_W'(val);
    case (idx)
      CFG_SET_BITS:   set_bits_q = val[SET_BITS_W-1:0];
      CFG_WAYS: begin
        ways_q = val[WAYS_REG_W-1:0];
        flush_model();
      end
      CFG_BLOCK_BITS: block_bits_q = val[BLOCK_BITS_W-1:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic send_access(input cmd_e c, input logic [63:0] a, input logic known,
                             input outcome_t exp);
    int gap;
    typed_checks.push_back('{known, exp});
    acc_if.valid   <= 1'b1;
    acc_if.command <= c;
    acc_if.address <= a;
    do @(posedge clk_i); while (!acc_if.ready);
    burst_left--;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 12);
      gap        = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        acc_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  // Hold off until every expected word is taken and the pipe is empty
  task automatic settle();
    acc_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_outcomes.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Result side: stall in bursts during alternate stretches
  initial begin
    int stall_left;
    int span;
    stall_left = 0;
    span       = 0;
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      span++;
      if (stall_left != 0) begin
        res_if.ready <= 1'b0;
        stall_left--;
      end else if (span[8] && $urandom_range(0, 2) == 0) begin
        res_if.ready <= 1'b0;
        stall_left = $urandom_range(0, 7);
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    outcome_t     got;
    outcome_t     want;
    outcome_t     predicted;
    typed_check_t note;
    if (!rst_ni) begin
      quiet_cycles = 0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        got = '{res_if.hit, res_if.eviction, res_if.modify_hit,
                res_if.hit_count, res_if.miss_count, res_if.eviction_count};
        if (pending_outcomes.size() == 0) begin
          $error("result word with nothing expected");
          failures++;
        end else begin
          want = pending_outcomes.pop_front();
          check_field("hit", 32'(want.hit), 32'(got.hit));
          check_field("eviction", 32'(want.eviction), 32'(got.eviction));
          check_field("modify_hit", 32'(want.modify_hit), 32'(got.modify_hit));
          check_field("hit_count", want.hit_count, got.hit_count);
          check_field("miss_count", want.miss_count, got.miss_count);
          check_field("eviction_count", want.eviction_count, got.eviction_count);
        end
      end
      if (acc_if.valid && acc_if.ready) begin
        note = typed_checks.pop_front();
        if (cache_lookup(cmd_e'(acc_if.command), acc_if.address, predicted))
          pending_outcomes.push_back(note.known ? note.exp : predicted);
      end
      if ((acc_if.valid && acc_if.ready) || (res_if.valid && res_if.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
  end

  initial begin
    while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clk_i);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    cmd_e        cmd;
    logic [63:0] addr;
    logic [63:0] tg;
    logic [63:0] st;
    logic [63:0] tag_pool [10];
    logic [63:0] set_pool [4];
    int          sb;
    int          nw;
    int          bb;
    int          sent;
    int          pick;
    rst_ni         <= 1'b0;
    cfg_we_i       <= 1'b0;
    cfg_index_i    <= CFG_SET_BITS;
    cfg_wdata_i    <= '0;
    acc_if.valid   <= 1'b0;
    acc_if.command <= CMD_IFETCH;
    acc_if.address <= '0;
    flush_model();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < N_DIRECTED; i++) begin
      if (DIRECTED[i].kind == ROW_WRITE) begin
        settle();
        write_reg(DIRECTED[i].reg_idx, int'(DIRECTED[i].reg_val));
        cfg_we_i <= 1'b0;
      end else begin
        send_access(DIRECTED[i].cmd, DIRECTED[i].addr, DIRECTED[i].known, DIRECTED[i].exp);
      end
    end

    for (int p = 0; p < N_PHASES; p++) begin
      settle();
      if (p < 6) begin
        sb = PHASE_SB[p];
        nw = PHASE_WAYS[p];
        bb = PHASE_BB[p];
      end else begin
        sb = $urandom_range(0, 7);
        nw = $urandom_range(0, 15);
        bb = $urandom_range(0, 63);
      end
      write_reg(CFG_SET_BITS, sb);
      // skip the flush now and then so lines survive a change of split
      if (p < 6 || $urandom_range(0, 1) == 1) write_reg(CFG_WAYS, nw);
      write_reg(CFG_BLOCK_BITS, bb);
      cfg_we_i <= 1'b0;
      sb = eff_set_bits();
      nw = eff_ways();
      bb = int'(block_bits_q);
      for (int k = 0; k < 10; k++) tag_pool[k] = {$urandom, $urandom};
      for (int k = 0; k < 4; k++) set_pool[k] = 64'($urandom_range(0, (1 << sb) - 1));
      sent = 0;
      addr = '0;
      while (sent < ITEMS_PER_PHASE) begin
        cmd  = cmd_e'($urandom_range(0, 3));
        pick = $urandom_range(0, 99);
        if (pick < 10) begin
          addr = {$urandom, $urandom};
        end else if (pick >= 20) begin
          // pooled set and tag, random offset: keeps sets contended
          tg   = tag_pool[$urandom_range(0, nw + 1)];
          st   = set_pool[$urandom_range(0, 3)];
          addr = {$urandom, $urandom} & ((64'd1 << bb) - 1);
          addr |= st << bb;
          if (bb + sb < 64) addr |= tg << (bb + sb);
        end
        send_access(cmd, addr, 1'b0, '0);
        sent++;
      end
    end

    settle();
    if (failures == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
